>>> rtl/sw_max_pkg.sv
// Shared types and constants of the sliding window maximum block.
`timescale 1ns / 1ps

package sw_max_pkg;

  localparam int unsigned DataW = 32;  // sample and result width
  localparam int unsigned CfgW  = 7;   // window_size register width

  typedef logic signed [DataW-1:0] sample_t;

  // one result transaction
  typedef struct packed {
    sample_t window_max;
    logic    final_window;
  } result_t;

endpackage

>>> rtl/sw_max_cell.sv
// One cell of the running-maximum chain: holds the max of the last i+1 samples.
`timescale 1ns / 1ps

module sw_max_cell
  import sw_max_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,       // sample accepted this cycle
  input  sample_t sample_i,   // incoming sample
  input  sample_t prev_i,     // neighbor's stored max (cell 0 gets the sample)
  output sample_t max_d_o,    // value this cell takes on the next edge
  output sample_t max_q_o     // stored max
);

  sample_t max_q;
  sample_t max_d;

  assign max_d = (prev_i > sample_i) ? prev_i : sample_i;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_d_o = max_d;
  assign max_q_o = max_q;

endmodule

>>> rtl/sw_max_skid.sv
// Output register with a skid stage for the result stream.
`timescale 1ns / 1ps

module sw_max_skid
  import sw_max_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,     // result pushed (only while ready_o)
  input  result_t push_data_i,
  output logic    ready_o,    // skid stage free
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;

  assign ready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && !out_ready_i) begin
      // output stalled: park a new result in the skid stage
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid stage did not move to output register");

  a_stall_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && push_i) |=> skid_valid_q)
    else $error("result pushed during stall was lost");
`endif

endmodule

>>> rtl/sliding_window_max_core.sv
// Top level of the sliding window maximum: cell chain, window control, output stage.
`timescale 1ns / 1ps

// Sliding window maximum over a stream of signed 32-bit samples. Each sample
// enters a chain of MAX_WINDOW cells; cell i holds the maximum of the last
// i+1 samples, so every cell updates with one compare against its neighbor.
// Once the current sequence holds at least window_size samples, each further
// sample yields the maximum of the last window_size samples; tlast on the
// input marks the end of a sequence and is carried on that result as tlast.
// A sequence shorter than the window yields no result. window_size is taken
// from the config channel (always ready), zero acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW; write it only while the block is idle.
// Rate: one sample per clock while tready is high; a result is registered on
// the master side when its sample is accepted. The critical path is one cell
// compare followed by the MAX_WINDOW-way selection of the window's cell. An
// output register plus a skid stage let a new sample in while a result waits;
// tready drops only once both are full.

module sliding_window_max_core
  import sw_max_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64  // longest window, 1..127 (window_size is CfgW = 7 bits wide)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config channel: window_size
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i,
  // sample stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DataW-1:0]  s_axis_tdata_i,   // [31:0] sample
  input  logic              s_axis_tlast_i,   // last_sample
  // result stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DataW-1:0]  m_axis_tdata_o,   // [31:0] window_max
  output logic              m_axis_tlast_o    // final_window
);

  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IdxW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WideW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [WideW-1:0] MaxWide = WideW'(MAX_WINDOW);
  localparam logic [CntW-1:0]  MaxCnt  = CntW'(MAX_WINDOW);

  // effective window, clamped at write time
  logic [CntW-1:0]  win_q, win_d;
  logic [WideW-1:0] cfg_wide;
  // samples seen in the current sequence, saturating at MAX_WINDOW
  logic [CntW-1:0]  seen_q, seen_d;
  logic [CntW-1:0]  seen_inc;

  logic    in_accept;
  logic    res_push;
  logic    skid_ready;
  sample_t sample;
  result_t res_data;
  result_t out_data;

  sample_t cell_d [MAX_WINDOW];
  sample_t cell_q [MAX_WINDOW];
  logic [IdxW-1:0] sel_idx;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = skid_ready;
  assign in_accept       = s_axis_tvalid_i & skid_ready;
  assign sample          = $signed(s_axis_tdata_i);

  // config: zero means one, oversize saturates
  always_comb begin
    cfg_wide = WideW'(cfg_data_i);
    win_d    = win_q;
    if (cfg_valid_i) begin
      if (cfg_wide == '0) begin
        win_d = CntW'(1);
      end else if (cfg_wide > MaxWide) begin
        win_d = MaxCnt;
      end else begin
        win_d = cfg_wide[CntW-1:0];
      end
    end
  end

  // sequence count
  always_comb begin
    seen_inc = (seen_q < MaxCnt) ? seen_q + CntW'(1) : seen_q;
    seen_d   = seen_q;
    if (in_accept) begin
      seen_d = s_axis_tlast_i ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= CntW'(1);
      seen_q <= '0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
    end
  end

  // chain of running-maximum cells
  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
    sample_t prev;
    if (gi == 0) begin : g_head
      assign prev = sample;
    end else begin : g_link
      assign prev = cell_q[gi-1];
    end
    sw_max_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (in_accept),
      .sample_i (sample),
      .prev_i   (prev),
      .max_d_o  (cell_d[gi]),
      .max_q_o  (cell_q[gi])
    );
  end

  // window of w samples ends in cell w-1
  assign sel_idx  = IdxW'(win_q - CntW'(1));
  assign res_push = in_accept & (seen_inc >= win_q);
  assign res_data = '{window_max: cell_d[sel_idx], final_window: s_axis_tlast_i};

  sw_max_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .ready_o     (skid_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data.window_max;
  assign m_axis_tlast_o = out_data.final_window;

`ifndef ASSERT_OFF
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= MaxCnt)
    else $error("sequence count beyond MAX_WINDOW");

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q != '0) && (win_q <= MaxCnt))
    else $error("effective window out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tlast_i) |=> (seen_q == '0))
    else $error("sequence count not cleared after last sample");
`endif

endmodule

>>> bench/tb_sliding_window_max_core.sv
// Self-checking bench for sliding_window_max_core: directed table, then random sequences.
`timescale 1ns / 1ps

module tb_sliding_window_max_core;
  import sw_max_pkg::*;

  localparam int MaxWin     = 64;
  localparam int RandItems  = 1750;
  localparam int HoldCycles = 150;     // long sink stall to back up the sample side
  localparam int DrainWait  = 4;       // wait after the drain before a window write; results are registered
  localparam int CycleLimit = 600000;

  // directed table: a row is a window_size write or one sample transaction
  typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_e;
  // how a sample row is checked: running model, typed "no result", typed value
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] data;       // sample, or window_size for ROW_CFG
    logic        is_last;
    chk_e        chk;
    logic [31:0] exp_max;
    logic        exp_final;
  } row_t;

  localparam int NumRows = 26;
  localparam row_t DirectedRows [NumRows] = '{
    // reset window is 1: every sample is its own max, extremes pass through
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_VALUE, 32'h7FFF_FFFF, 1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHK_VALUE, 32'h8000_0000, 1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, CHK_VALUE, 32'hFFFF_FFFF, 1'b1},
    // zero window acts as one
    '{ROW_CFG,    32'd0,         1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd5,         1'b1, CHK_VALUE, 32'd5,         1'b1},
    // sequence shorter than the window: nothing comes out
    '{ROW_CFG,    32'd3,         1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd7,         1'b0, CHK_NONE,  32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd8,         1'b1, CHK_NONE,  32'd0,         1'b0},
    // signed compare across the sign boundary
    '{ROW_SAMPLE, 32'd1,         1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFB, 1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, CHK_MODEL, 32'd0,         1'b0},
    // oversize window saturates at MaxWin; short run stays silent
    '{ROW_CFG,    32'd127,       1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd5,         1'b0, CHK_NONE,  32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd6,         1'b1, CHK_NONE,  32'd0,         1'b0},
    // window grows in the middle of a sequence (written while idle)
    '{ROW_CFG,    32'd2,         1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd3,         1'b0, CHK_NONE,  32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd9,         1'b0, CHK_VALUE, 32'd9,         1'b0},
    '{ROW_CFG,    32'd4,         1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd1,         1'b0, CHK_NONE,  32'd0,         1'b0},
    '{ROW_SAMPLE, 32'd2,         1'b1, CHK_VALUE, 32'd9,         1'b1},
    // full-width window, single short run
    '{ROW_CFG,    32'd64,        1'b0, CHK_MODEL, 32'd0,         1'b0},
    '{ROW_SAMPLE, 32'h1234_5678, 1'b1, CHK_NONE,  32'd0,         1'b0},
    '{ROW_CFG,    32'd1,         1'b0, CHK_MODEL, 32'd0,         1'b0}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgW-1:0]   cfg_data_i;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [DataW-1:0]  s_axis_tdata_i;   // [31:0] sample
  logic              s_axis_tlast_i;   // last_sample
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [DataW-1:0]  m_axis_tdata_o;   // [31:0] window_max
  logic              m_axis_tlast_o;   // final_window

  sliding_window_max_core #(
    .MAX_WINDOW(MaxWin)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------------------
  // Window-max tracker: own copy of the sample history, run length, write slot
  // and window register. Updated once per accepted sample transaction.
  // ---------------------------------------------------------------------------
  sample_t         hist_mem [MaxWin];
  int              hist_seen;
  int              hist_head;
  logic [CfgW-1:0] win_reg;

  result_t pending_max_q [$];   // window maxima still owed by the DUT
  int      err_count;
  int      cycle_count;

  // run-level knobs shared with the sink process
  bit tx_burst;
  bit rx_burst;
  bit hold_req;

  // Push one sample into the history and fill win_max with the maximum over the
  // last window samples; returns 1 when the window is full.
  function automatic bit track_window_max(input sample_t smp, input logic is_last,
                                          output result_t win_max);
    int      span;
    int      idx;
    sample_t best;
    bit      fired;
    span = int'(win_reg);
    if (span == 0) span = 1;           // zero window acts as one
    if (span > MaxWin) span = MaxWin;  // oversize window saturates
    hist_mem[hist_head] = smp;
    hist_head = (hist_head + 1) % MaxWin;
    if (hist_seen < MaxWin) hist_seen++;
    fired = (hist_seen >= span);
    best  = smp;
    for (int i = 1; i < span; i++) begin
      idx = (hist_head + 2 * MaxWin - 1 - i) % MaxWin;
      if (hist_mem[idx] > best) best = hist_mem[idx];
    end
    win_max.window_max   = best;
    win_max.final_window = is_last;
    // end of sequence: next sample starts a fresh run
    if (is_last) begin
      hist_seen = 0;
      hist_head = 0;
    end
    return fired;
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return sample_t'($urandom_range(0, 15)) - 8;  // small values, many ties
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side and config writes
  // ---------------------------------------------------------------------------

  // One sample transaction. tvalid stays high between back-to-back samples;
  // it is dropped only when a gap is drawn.
  task automatic send_sample(input sample_t smp, input logic is_last, input chk_e chk,
                             input result_t typed);
    int      gap;
    result_t win_max;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tlast_i  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // accepted at this edge
    if (chk == CHK_MODEL) begin
      if (track_window_max(smp, is_last, win_max)) begin
        pending_max_q.insert(pending_max_q.size(), win_max);
      end
    end else begin
      void'(track_window_max(smp, is_last, win_max));
      if (chk == CHK_VALUE) pending_max_q.insert(pending_max_q.size(), typed);
    end
  endtask

  // window_size write: only once the DUT has drained. A sample with no result
  // may still be in flight, so keep waiting after the last result.
  task automatic write_window(input logic [CfgW-1:0] wsize);
    s_axis_tvalid_i <= 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= wsize;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_reg = wsize;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    row_t    row;
    result_t typed;
    int      sent;
    int      phase;
    int      nseq;
    int      span;
    int      seq_len;
    bit      keep_open;
    logic [CfgW-1:0] wsize;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    hold_req        = 1'b0;
    err_count       = 0;
    cycle_count     = 0;
    hist_seen       = 0;
    hist_head       = 0;
    win_reg         = CfgW'(1);
    foreach (hist_mem[i]) hist_mem[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirectedRows[r]) begin
      row = DirectedRows[r];
      if (row.kind == ROW_CFG) begin
        write_window(row.data[CfgW-1:0]);
      end else begin
        typed.window_max   = row.exp_max;
        typed.final_window = row.exp_final;
        send_sample(row.data, row.is_last, row.chk, typed);
      end
    end

    // random phases: a window setting, then a few sequences under it
    typed = '0;
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: wsize = CfgW'($urandom_range(1, 8));
        5:             wsize = CfgW'($urandom_range(9, 40));
        6:             wsize = CfgW'(MaxWin);
        7:             wsize = CfgW'($urandom_range(MaxWin + 1, 127));
        8:             wsize = '0;
        default:       wsize = CfgW'($urandom_range(0, 127));
      endcase
      // back-pressure phases: one result per sample, sink freezes, source keeps pushing
      if (phase == 1 || phase == 8) wsize = CfgW'(1);
      write_window(wsize);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);

      span = (wsize == '0) ? 1 : ((int'(wsize) > MaxWin) ? MaxWin : int'(wsize));
      nseq = $urandom_range(1, 4);
      if (phase == 1 || phase == 8) begin
        tx_burst = 1'b1;
        hold_req = 1'b1;
        nseq     = 1;
      end

      for (int q = 0; q < nseq; q++) begin
        case ($urandom_range(0, 9))
          0:       seq_len = (span > 1) ? $urandom_range(1, span - 1) : 1;  // too short
          1:       seq_len = span + $urandom_range(40, 120);  // long run, can pass count saturation
          default: seq_len = span + $urandom_range(0, 12);
        endcase
        if (hold_req) seq_len = 60;
        // leave the run open now and then so the next window applies mid-sequence
        keep_open = (q == nseq - 1) && ($urandom_range(0, 4) == 0);
        for (int i = 0; i < seq_len; i++) begin
          send_sample(draw_sample(), (i == seq_len - 1) && !keep_open, CHK_MODEL, typed);
          sent++;
        end
      end
      phase++;
    end

    // drain, then watch a little longer for stray results
    s_axis_tvalid_i <= 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: sink stalls drawn per transaction, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap      = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // compare every result transaction against the oldest owed window max
  always @(posedge clk_i) begin
    result_t owed;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_max_q.size() == 0) begin
        $error("result with nothing pending: window_max %0d final_window %0b",
               $signed(m_axis_tdata_o), m_axis_tlast_o);
        err_count++;
      end else begin
        owed = pending_max_q.pop_front();
        if (m_axis_tdata_o !== owed.window_max) begin
          $error("window_max mismatch: expected %0d, actual %0d",
                 owed.window_max, $signed(m_axis_tdata_o));
          err_count++;
        end
        if (m_axis_tlast_o !== owed.final_window) begin
          $error("final_window mismatch: expected %0b, actual %0b",
                 owed.final_window, m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

endmodule

>>> files.f
rtl/sw_max_pkg.sv
rtl/sw_max_cell.sv
rtl/sw_max_skid.sv
rtl/sliding_window_max_core.sv
bench/tb_sliding_window_max_core.sv
